>>> rtl/differential_drive_steering_defines.svh
// ----------------------------------------------------------------------------
// Differential drive steering assertion macros
// Shared property templates for the checker of the steering block.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_STEERING_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_STEERING_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define DDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("steering check failed");

// Next-cycle implication, sampled on clk and disabled while in reset.
`define DDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("steering check failed");

`endif

>>> rtl/dds_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive steering package
// Constants, arctangent table and inter-module types of the steering block.
// ----------------------------------------------------------------------------
package dds_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int STAGES        = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    // Vectoring datapath width, magnitude width, residual angle width, cosine and sine width.
    localparam int VW = 36;
    localparam int XW = 34;
    localparam int RW = 33;
    localparam int CW = 32;

    // Reciprocal of the full-convergence CORDIC gain in Q0.30.
    localparam logic [29:0] INV_GAIN = 30'd652032874;

    localparam logic [15:0] VGAIN_RESET = 16'd256;
    localparam logic [15:0] TGAIN_RESET = 16'd256;

    // Register indexes on the configuration port (selected by paddr[2]).
    localparam logic REG_VGAIN = 1'b0;
    localparam logic REG_TGAIN = 1'b1;

    typedef struct packed {
        logic [XW-1:0] mag_x;
        logic [31:0]   angle;
        logic [15:0]   head;
    } vec_res_t;

    typedef struct packed {
        logic signed [CW-1:0] cos_v;
        logic signed [CW-1:0] sin_v;
        logic                 wide;
        logic [XW-1:0]        mag_x;
    } rot_res_t;

    typedef struct packed {
        logic                 clipped;
        logic signed [15:0]   right_speed;
        logic signed [15:0]   left_speed;
    } wheel_out_t;

    // atan(2^-idx) in 32-bit binary angle units, truncated.
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051D;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2E;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2F9;
            15: r = 32'h0000517C;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A2F;
            19: r = 32'h00000517;
            20: r = 32'h0000028B;
            21: r = 32'h00000145;
            22: r = 32'h000000A2;
            23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/dds_vectoring.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC pipeline
// Turns the desired vector onto the x axis, giving its scaled length and angle.
// ----------------------------------------------------------------------------
module dds_vectoring (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] heading,
    output logic               out_vld,
    output dds_pkg::vec_res_t  out_res
);
    import dds_pkg::*;

    logic signed [VW-1:0] x_reg [0:STAGES];
    logic signed [VW-1:0] y_reg [0:STAGES];
    logic [31:0]          z_reg [0:STAGES];
    logic [15:0]          h_reg [0:STAGES];
    logic                 v_reg [0:STAGES];

    logic signed [VW-1:0] x_in;
    logic signed [VW-1:0] y_in;

    assign x_in = VW'(dir_x) <<< 16;
    assign y_in = VW'(dir_y) <<< 16;

    // A vector pointing left is first turned by a half turn.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dir_x[15])
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= 32'h80000000;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= 32'h00000000;
            end
            h_reg[0] <= heading;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_vld;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][VW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
                h_reg[i+1] <= h_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end
    end

    assign out_vld       = v_reg[STAGES];
    assign out_res.mag_x = x_reg[STAGES][XW-1:0];
    assign out_res.angle = z_reg[STAGES];
    assign out_res.head  = h_reg[STAGES];

endmodule

>>> rtl/dds_rotation.sv
// ----------------------------------------------------------------------------
// Rotation CORDIC pipeline
// Forms the wrapped heading error and gives its cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module dds_rotation (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  dds_pkg::vec_res_t in_res,
    output logic              out_vld,
    output dds_pkg::rot_res_t out_res
);
    import dds_pkg::*;

    logic signed [CW-1:0] c_reg [0:STAGES];
    logic signed [CW-1:0] s_reg [0:STAGES];
    logic signed [RW-1:0] r_reg [0:STAGES];
    logic                 w_reg [0:STAGES];
    logic [XW-1:0]        m_reg [0:STAGES];
    logic                 v_reg [0:STAGES];

    logic [31:0] err_u;
    logic        wide;
    logic [31:0] ang_u;

    assign err_u = in_res.angle - {in_res.head, 16'h0000};
    // The error is at least a quarter turn in magnitude, a quarter turn included.
    assign wide  = (err_u[31] != err_u[30]) || (err_u == 32'hC0000000);
    assign ang_u = wide ? {~err_u[31], err_u[30:0]} : err_u;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0] <= CW'(INV_GAIN);
            s_reg[0] <= '0;
            r_reg[0] <= RW'($signed(ang_u));
            w_reg[0] <= wide;
            m_reg[0] <= in_res.mag_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_vld;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!r_reg[i][RW-1])
                begin
                    c_reg[i+1] <= c_reg[i] - (s_reg[i] >>> i);
                    s_reg[i+1] <= s_reg[i] + (c_reg[i] >>> i);
                    r_reg[i+1] <= r_reg[i] - RW'(atan_entry(i));
                end
                else
                begin
                    c_reg[i+1] <= c_reg[i] + (s_reg[i] >>> i);
                    s_reg[i+1] <= s_reg[i] - (c_reg[i] >>> i);
                    r_reg[i+1] <= r_reg[i] + RW'(atan_entry(i));
                end
                w_reg[i+1] <= w_reg[i];
                m_reg[i+1] <= m_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end
    end

    assign out_vld       = v_reg[STAGES];
    assign out_res.cos_v = w_reg[STAGES] ? -c_reg[STAGES] : c_reg[STAGES];
    assign out_res.sin_v = w_reg[STAGES] ? -s_reg[STAGES] : s_reg[STAGES];
    assign out_res.wide  = w_reg[STAGES];
    assign out_res.mag_x = m_reg[STAGES];

endmodule

>>> rtl/dds_wheel.sv
// ----------------------------------------------------------------------------
// Wheel command datapath
// Scales magnitude into speed, applies cosine and turn terms, and saturates.
// ----------------------------------------------------------------------------
module dds_wheel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  dds_pkg::rot_res_t  in_res,
    input  logic [15:0]        velocity_gain,
    input  logic [15:0]        turning_gain,
    output logic               out_vld,
    output dds_pkg::wheel_out_t out_data
);
    import dds_pkg::*;

    logic [5:0] v_reg;

    // Stage 1: magnitude times 1/K as two partial products.
    logic [46:0]          pm_hi_reg, pm_lo_reg;
    logic signed [CW-1:0] c1_reg, s1_reg;
    logic                 w1_reg;
    // Stage 2: magnitude as an unsigned integer (Q18.0).
    logic [17:0]          mag_reg;
    logic signed [CW-1:0] c2_reg, s2_reg;
    logic                 w2_reg;
    // Stage 3: base speed.
    logic [25:0]          speed_reg;
    logic signed [CW-1:0] c3_reg, s3_reg;
    logic                 w3_reg;
    // Stage 4: speed times cosine and sine, split in halves.
    logic signed [45:0]   pc_hi_reg, pc_lo_reg, ps_hi_reg, ps_lo_reg;
    logic                 w4_reg;
    // Stage 5: base and unscaled turn.
    logic signed [29:0]   base5_reg, t1_reg;
    logic                 w5_reg;
    // Stage 6: scaled turn.
    logic signed [29:0]   base6_reg;
    logic signed [38:0]   turn_reg;
    logic                 w6_reg;

    logic [63:0]          mag_sum;
    logic [33:0]          speed_prod;
    logic signed [59:0]   sum_c, sum_s;
    logic signed [46:0]   turn_prod;
    logic signed [39:0]   left_raw, right_raw;
    logic                 left_hi, left_lo, right_hi, right_lo;

    assign mag_sum    = {pm_hi_reg, 17'h00000} + 64'(pm_lo_reg);
    assign speed_prod = velocity_gain * mag_reg;
    assign sum_c      = (60'(pc_hi_reg) <<< 13) + 60'(pc_lo_reg);
    assign sum_s      = (60'(ps_hi_reg) <<< 13) + 60'(ps_lo_reg);
    assign turn_prod  = t1_reg * $signed({1'b0, turning_gain});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_hi_reg <= in_res.mag_x[33:17] * INV_GAIN;
            pm_lo_reg <= in_res.mag_x[16:0] * INV_GAIN;
            c1_reg    <= in_res.cos_v;
            s1_reg    <= in_res.sin_v;
            w1_reg    <= in_res.wide;

            mag_reg   <= mag_sum[63:46];
            c2_reg    <= c1_reg;
            s2_reg    <= s1_reg;
            w2_reg    <= w1_reg;

            speed_reg <= speed_prod[33:8];
            c3_reg    <= c2_reg;
            s3_reg    <= s2_reg;
            w3_reg    <= w2_reg;

            pc_hi_reg <= $signed({1'b0, speed_reg[25:13]}) * c3_reg;
            pc_lo_reg <= $signed({1'b0, speed_reg[12:0]}) * c3_reg;
            ps_hi_reg <= $signed({1'b0, speed_reg[25:13]}) * s3_reg;
            ps_lo_reg <= $signed({1'b0, speed_reg[12:0]}) * s3_reg;
            w4_reg    <= w3_reg;

            base5_reg <= sum_c[59:30];
            t1_reg    <= sum_s[59:30];
            w5_reg    <= w4_reg;

            base6_reg <= base5_reg;
            turn_reg  <= turn_prod[46:8];
            w6_reg    <= w5_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], in_vld};
    end

    // The turn goes to the right wheel, or to the left when the error is wide.
    always_comb
    begin
        if (w6_reg)
        begin
            left_raw  = 40'(base6_reg) + 40'(turn_reg);
            right_raw = 40'(base6_reg) - 40'(turn_reg);
        end
        else
        begin
            left_raw  = 40'(base6_reg) - 40'(turn_reg);
            right_raw = 40'(base6_reg) + 40'(turn_reg);
        end
    end

    assign left_hi  = left_raw > 40'sd32767;
    assign left_lo  = left_raw < -40'sd32768;
    assign right_hi = right_raw > 40'sd32767;
    assign right_lo = right_raw < -40'sd32768;

    assign out_data.left_speed  = left_hi ? 16'sh7FFF : (left_lo ? 16'sh8000 : left_raw[15:0]);
    assign out_data.right_speed = right_hi ? 16'sh7FFF :
                                  (right_lo ? 16'sh8000 : right_raw[15:0]);
    assign out_data.clipped     = left_hi | left_lo | right_hi | right_lo;
    assign out_vld              = v_reg[5];

endmodule

>>> rtl/dds_outbuf.sv
// ----------------------------------------------------------------------------
// Output register with skid stage
// Holds results for the downstream side and throttles the pipeline.
// ----------------------------------------------------------------------------
module dds_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dds_pkg::wheel_out_t push_data,
    input  logic                out_ready,
    output logic                out_vld,
    output dds_pkg::wheel_out_t out_data,
    output logic                pipe_en
);
    import dds_pkg::*;

    logic       out_vld_reg, skid_vld_reg;
    wheel_out_t out_data_reg, skid_data_reg;
    logic       pop;

    assign pop     = out_vld_reg & out_ready;
    // The pipeline advances only while the skid stage can take one more result.
    assign pipe_en = ~skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (pop)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !pop)
                skid_vld_reg <= 1'b1;
            else
                out_vld_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_vld_reg && !pop)
                skid_data_reg <= push_data;
            else
                out_data_reg <= push_data;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_data_reg;

endmodule

>>> rtl/differential_drive_steering.sv
// ----------------------------------------------------------------------------
// Differential drive steering
// Wheel speed commands from a desired vector and the robot heading.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries one transaction per request: dir_x, dir_y
// and heading. The master stream returns one transaction per request with
// both wheel speeds in tdata and the saturation flag in tuser, in order.
// The gains sit behind the APB port at byte addresses 0 and 4 and should be
// written only while no transaction is in flight.
// From input acceptance to output valid a result passes one pre-rotation
// stage and the vectoring CORDIC, one error stage and the rotation CORDIC,
// six multiply stages and the output register, with the first of them
// loaded at the accepting edge. One transaction is taken every cycle while
// the skid stage is empty.
// The whole pipeline advances on one enable. When the receiver stalls, the
// output register holds its result and a skid stage takes the next one; only
// when the skid stage is full does s_axis_tready drop, so no result is lost
// or repeated. Reset empties the pipeline and both output stages and loads
// both gains with 1.0 (256 in Q8.8).
// ----------------------------------------------------------------------------
module differential_drive_steering (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // dir_x[15:0], dir_y[31:16], heading[47:32]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // left_speed[15:0], right_speed[31:16]
    output logic [0:0]  m_axis_tuser,   // clipped[0]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dds_pkg::*;

    logic [15:0] vgain_reg;
    logic [15:0] tgain_reg;
    logic        cfg_wr;

    logic        pipe_en;
    logic        vec_vld, rot_vld, wheel_vld;
    vec_res_t    vec_res;
    rot_res_t    rot_res;
    wheel_out_t  wheel_data, out_data;

    // Register file: the register index is paddr[2].
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vgain_reg <= VGAIN_RESET;
            tgain_reg <= TGAIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_VGAIN: vgain_reg <= pwdata[15:0];
                REG_TGAIN: tgain_reg <= pwdata[15:0];
                default:   vgain_reg <= vgain_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_VGAIN: prdata = {16'h0000, vgain_reg};
            REG_TGAIN: prdata = {16'h0000, tgain_reg};
            default:   prdata = 32'h00000000;
        endcase
    end

    // A request enters whenever the pipeline is advancing.
    assign s_axis_tready = pipe_en;

    dds_vectoring u_vec (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .in_vld  (s_axis_tvalid),
        .dir_x   (s_axis_tdata[15:0]),
        .dir_y   (s_axis_tdata[31:16]),
        .heading (s_axis_tdata[47:32]),
        .out_vld (vec_vld),
        .out_res (vec_res)
    );

    dds_rotation u_rot (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .in_vld  (vec_vld),
        .in_res  (vec_res),
        .out_vld (rot_vld),
        .out_res (rot_res)
    );

    dds_wheel u_wheel (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (pipe_en),
        .in_vld        (rot_vld),
        .in_res        (rot_res),
        .velocity_gain (vgain_reg),
        .turning_gain  (tgain_reg),
        .out_vld       (wheel_vld),
        .out_data      (wheel_data)
    );

    // The last multiply stage hands its result over whenever the pipeline moves.
    dds_outbuf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pipe_en & wheel_vld),
        .push_data (wheel_data),
        .out_ready (m_axis_tready),
        .out_vld   (m_axis_tvalid),
        .out_data  (out_data),
        .pipe_en   (pipe_en)
    );

    assign m_axis_tdata = {out_data.right_speed, out_data.left_speed};
    assign m_axis_tuser = out_data.clipped;

endmodule

>>> rtl/dds_checker.sv
// ----------------------------------------------------------------------------
// Differential drive steering checker
// Port-level properties of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
`include "differential_drive_steering_defines.svh"

module dds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic out_stall;
    logic out_clip;
    logic any_rail;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_clip  = m_axis_tvalid && m_axis_tuser[0];
    assign any_rail  = (m_axis_tdata[15:0] == 16'h7FFF) || (m_axis_tdata[15:0] == 16'h8000) ||
                       (m_axis_tdata[31:16] == 16'h7FFF) || (m_axis_tdata[31:16] == 16'h8000);

    // A stalled result keeps its value until the transaction completes.
    `DDS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))

    // Requests are refused only when a result is backed up at the output.
    `DDS_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid)

    // The clip flag comes only with a wheel pinned at a rail.
    `DDS_ASSERT_NOW(a_clip_rail, out_clip, any_rail)

endmodule

bind differential_drive_steering dds_checker u_dds_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Differential drive steering testbench
// Drives desired vectors and headings into the steering block, predicts the
// wheel speed commands with an independent CORDIC model, and compares every
// result transaction in order. The gains are changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import dds_pkg::*;

    // One request: the desired vector and the heading.
    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_x;
    } steer_req_t;

    // One predicted wheel command.
    typedef struct {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic               clipped;
    } wheel_cmd_t;

    // Latency from the head of the block, plus margin.
    localparam int PIPE_LAT = 2 * STAGES + 9;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // dir_x[15:0], dir_y[31:16], heading[47:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // left_speed[15:0], right_speed[31:16]
    logic [0:0]  m_axis_tuser;   // clipped[0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    differential_drive_steering DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // The testbench keeps its own copy of both gains.
    logic [15:0] vel_gain_q88;
    logic [15:0] turn_gain_q88;

    steer_req_t request_queue[$];
    wheel_cmd_t expected_cmds[$];

    int  error_count;
    bit  calm_mode;         // When set, neither side idles.
    bit  hold_sink;         // Long receiver hold-off request.
    int  sink_hold_cycles;  // Counted down in the sink process.
    int  src_gap;
    int  sink_gap;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Floor division by a power of two is an arithmetic right shift.
    function automatic logic signed [63:0] asr(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [63:0] v,
                                                   inout logic clip);
        if (v > 64'sd32767)
        begin
            clip = 1'b1;
            return 16'sh7fff;
        end
        if (v < -64'sd32768)
        begin
            clip = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Predicts the wheel commands for one request under the current gains.
    function automatic wheel_cmd_t predict_wheels(input steer_req_t req);
        logic signed [63:0] vx, vy, dvx, dvy;
        logic [31:0]        dir_ang, err_u;
        logic signed [63:0] err, rem, cs, sn, dcs, dsn;
        logic signed [63:0] mag, spd, base, t1, turn, lft, rgt;
        logic [127:0]       prod;
        logic               wide;
        logic               clip;
        wheel_cmd_t         cmd;
        vx = 64'(req.dir_x) * 65536;
        vy = 64'(req.dir_y) * 65536;
        dir_ang = 32'd0;
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            dir_ang = 32'h80000000;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dvx = asr(vy, i);
            dvy = asr(vx, i);
            if (vy >= 0)
            begin
                vx = vx + dvx;
                vy = vy - dvy;
                dir_ang = dir_ang + atan_entry(i);
            end
            else
            begin
                vx = vx - dvx;
                vy = vy + dvy;
                dir_ang = dir_ang - atan_entry(i);
            end
        end
        prod = 128'(vx) * 128'(64'd652032874);
        mag = 64'(prod >> 46);
        spd = 64'((128'(vel_gain_q88) * 128'(mag)) >> 8);

        err_u = dir_ang - {req.heading, 16'h0000};
        err = 64'(signed'(err_u));
        wide = (err >= 64'sh40000000) || (err <= -64'sh40000000);
        rem = wide ? 64'(signed'(err_u + 32'h80000000)) : err;
        cs = 64'sd652032874;
        sn = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dcs = asr(sn, i);
            dsn = asr(cs, i);
            if (rem >= 0)
            begin
                cs = cs - dcs;
                sn = sn + dsn;
                rem = rem - 64'(atan_entry(i));
            end
            else
            begin
                cs = cs + dcs;
                sn = sn - dsn;
                rem = rem + 64'(atan_entry(i));
            end
        end
        if (wide)
        begin
            cs = -cs;
            sn = -sn;
        end
        base = asr(spd * cs, 30);
        t1 = asr(spd * sn, 30);
        turn = asr(t1 * 64'(turn_gain_q88), 8);
        if (wide)
        begin
            lft = base + turn;
            rgt = base - turn;
        end
        else
        begin
            lft = base - turn;
            rgt = base + turn;
        end
        clip = 1'b0;
        cmd.left_speed = clamp16(lft, clip);
        cmd.right_speed = clamp16(rgt, clip);
        cmd.clipped = clip;
        return cmd;
    endfunction

    // Source side: offers the head of the request queue, with random gaps.
    // A transaction is accepted on the edge where tvalid and tready are high;
    // the prediction is made at that point with the gains then in force.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_cmds.push_back(predict_wheels(steer_req_t'(s_axis_tdata)));
                void'(request_queue.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // Hold the offered transaction until it is taken.
            end
            else if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (request_queue.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= request_queue[0];
                if (!calm_mode && $urandom_range(0, 9) == 0)
                    src_gap <= $urandom_range(1, 18);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random stalls, plus one long hold-off counted here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready    <= 1'b0;
            sink_gap         <= 0;
            sink_hold_cycles <= 0;
        end
        else
        begin
            if (hold_sink && sink_hold_cycles == 0)
            begin
                sink_hold_cycles <= 150;
                m_axis_tready <= 1'b0;
            end
            else if (sink_hold_cycles > 1)
            begin
                sink_hold_cycles <= sink_hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end
            else if (sink_hold_cycles == 1)
            begin
                // Leave a nonzero marker so the request is not re-armed.
                sink_hold_cycles <= -1;
                m_axis_tready <= 1'b1;
            end
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm_mode && $urandom_range(0, 7) == 0)
                    sink_gap <= $urandom_range(1, 18);
            end
        end
    end

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_cmds.size() == 0)
            begin
                $error("unexpected result transaction %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                wheel_cmd_t want;
                want = expected_cmds.pop_front();
                if (m_axis_tdata[15:0] !== want.left_speed)
                begin
                    $error("left_speed expected %0d actual %0d",
                           want.left_speed, $signed(m_axis_tdata[15:0]));
                    error_count++;
                end
                if (m_axis_tdata[31:16] !== want.right_speed)
                begin
                    $error("right_speed expected %0d actual %0d",
                           want.right_speed, $signed(m_axis_tdata[31:16]));
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.clipped)
                begin
                    $error("clipped expected %0d actual %0d",
                           want.clipped, m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    task automatic add_req(input logic [15:0] x, input logic [15:0] y, input logic [15:0] h);
        steer_req_t r;
        r.dir_x = x;
        r.dir_y = y;
        r.heading = h;
        request_queue.push_back(r);
    endtask

    // Waits for the block to drain completely before touching the gains.
    task automatic wait_idle();
        while (request_queue.size() > 0 || s_axis_tvalid || expected_cmds.size() > 0)
            @(posedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; pready is always high.
    // An idle cycle follows so that back-to-back writes never drive the
    // bus twice in the same time step.
    task automatic write_gain(input logic reg_idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_VGAIN)
            vel_gain_q88 = value;
        else
            turn_gain_q88 = value;
        @(posedge clk);
    endtask

    // Random request; mostly moderate vectors, some at full scale.
    task automatic add_random(input int count);
        logic [15:0] x, y;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    x = 16'($urandom());
                    y = 16'($urandom());
                end
                1:
                begin
                    x = 16'($signed($urandom_range(0, 8192)) - 4096);
                    y = 16'($signed($urandom_range(0, 8192)) - 4096);
                end
                2:
                begin
                    x = ($urandom_range(0, 1)) ? 16'h0000 : 16'($urandom());
                    y = ($urandom_range(0, 1)) ? 16'h0000 : 16'($urandom());
                end
                default:
                begin
                    x = 16'($signed($urandom_range(0, 1024)) - 512);
                    y = 16'($signed($urandom_range(0, 1024)) - 512);
                end
            endcase
            add_req(x, y, 16'($urandom()));
        end
    endtask

    initial
    begin
        logic [15:0] vg_set[5];
        logic [15:0] tg_set[5];
        error_count   = 0;
        calm_mode     = 0;
        hold_sink     = 0;
        vel_gain_q88  = 16'd256;
        turn_gain_q88 = 16'd256;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset gains: extremes, zero vector,
        // errors of exactly plus and minus a quarter turn, and a half turn.
        add_req(16'h0000, 16'h0000, 16'h0000);
        add_req(16'h0000, 16'h0000, 16'h8000);
        add_req(16'h1000, 16'h0000, 16'h0000);
        add_req(16'h1000, 16'h0000, 16'h4000);
        add_req(16'h1000, 16'h0000, 16'hc000);
        add_req(16'h1000, 16'h0000, 16'h8000);
        add_req(16'h0000, 16'h1000, 16'h0000);
        add_req(16'h0000, 16'hf000, 16'h0000);
        add_req(16'hf000, 16'h0000, 16'h0000);
        add_req(16'h7fff, 16'h7fff, 16'h2000);
        add_req(16'h8000, 16'h8000, 16'h7fff);
        add_req(16'h8000, 16'h7fff, 16'h8000);
        add_req(16'h7fff, 16'h8000, 16'hffff);
        add_req(16'hffff, 16'hffff, 16'h0001);
        add_req(16'h0001, 16'h0000, 16'h5555);
        add_req(16'h0800, 16'h0800, 16'hd000);
        wait_idle();

        // Long receiver hold-off while requests keep coming.
        hold_sink = 1;
        add_random(200);
        wait_idle();
        hold_sink = 0;

        // Phases across gain settings, extremes included.
        vg_set = '{16'd0, 16'hffff, 16'd128, 16'd700, 16'd256};
        tg_set = '{16'hffff, 16'd0, 16'd1024, 16'd64, 16'd256};
        for (int p = 0; p < 5; p++)
        begin
            write_gain(REG_VGAIN, vg_set[p]);
            write_gain(REG_TGAIN, tg_set[p]);
            if (p == 4)
                calm_mode = 1;
            add_random(180);
            wait_idle();
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> differential_drive_steering.f
+incdir+rtl
rtl/dds_pkg.sv
rtl/dds_vectoring.sv
rtl/dds_rotation.sv
rtl/dds_wheel.sv
rtl/dds_outbuf.sv
rtl/differential_drive_steering.sv
rtl/dds_checker.sv
dv/tb_top.sv
